// ===== src/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg: shared definitions for the resolution tier governor
// Field widths, reset values, parameter defaults and the control structs
// that pass between the window, tier and top-level modules.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int LAT_W    = 24;
   localparam int BUDGET_W = 20;
   localparam int DIV_W    = 4;

   localparam int WINDOW_DEF      = 16;
   localparam int PROMOTE_RUN_DEF = 30;
   localparam int COOLDOWN_DEF    = 30;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd33333;
   localparam logic [DIV_W-1:0]    DIV_ONE      = 4'd1;
   localparam logic [DIV_W-1:0]    DIV_TWO      = 4'd2;
   localparam logic [DIV_W-1:0]    DIV_FOUR     = 4'd4;

   // register index on the write channel
   typedef enum logic [1:0] {
      REG_ENABLE    = 2'd0,
      REG_BUDGET    = 2'd1,
      REG_START_DIV = 2'd2
   } art_reg_type;

   // window control from the top level
   typedef struct packed {
      logic step;    // an enabled item is being processed
      logic clear;   // empty the window (enable toggle or tier change)
   } art_win_ctl_type;

   // decoded configuration write
   typedef struct packed {
      logic                toggle;     // enable written with a new value
      logic                budget_wr;
      logic                div_wr;
      logic [BUDGET_W-1:0] data;
   } art_cfg_type;

   // per-item decision result
   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic             overrun;
      logic             changed;
   } art_tier_res_type;

endpackage

// ===== src/art_window.sv =====
// ----------------------------------------------------------------------------
// art_window: latency ring and running sum
// Keeps the last WINDOW samples in a ring memory with a running sum and a
// fill count. The ring read is registered and always points at the slot the
// next item will overwrite.
// ----------------------------------------------------------------------------
module art_window #(
   parameter int WINDOW = art_pkg::WINDOW_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  art_pkg::art_win_ctl_type                      ctl,
   input  logic [art_pkg::LAT_W-1:0]                     latency,
   output logic [art_pkg::LAT_W+$clog2(WINDOW)-1:0]      sum_upd,
   output logic                                          full_upd
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = art_pkg::LAT_W + IDX_W;

   logic [art_pkg::LAT_W-1:0] ring_mem [WINDOW];
   logic [art_pkg::LAT_W-1:0] old_ff;

   logic [IDX_W-1:0] idx_ff, idx_in, idx_upd;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_upd;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             full_now;

   always_comb begin
      full_now = (cnt_ff == CNT_W'(WINDOW));
      idx_upd  = (idx_ff == IDX_W'(WINDOW - 1)) ? '0 : idx_ff + 1'b1;
      cnt_upd  = full_now ? cnt_ff : cnt_ff + 1'b1;
      full_upd = (cnt_upd == CNT_W'(WINDOW));
      // oldest sample drops out only once the window is full
      sum_upd  = sum_ff - (full_now ? SUM_W'(old_ff) : '0) + SUM_W'(latency);

      idx_in = idx_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (ctl.clear) begin
         idx_in = '0;
         cnt_in = '0;
         sum_in = '0;
      end else if (ctl.step) begin
         idx_in = idx_upd;
         cnt_in = cnt_upd;
         sum_in = sum_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   // write slot idx_ff, read the slot of the following item
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         ring_mem[idx_ff] <= latency;
      end
      old_ff <= ring_mem[idx_in];
   end

endmodule

// ===== src/art_tier.sv =====
// ----------------------------------------------------------------------------
// art_tier: tier decision
// Holds the divisor, promote streak, cooldown and budget thresholds, and
// makes the per-item overrun and tier step decision.
// ----------------------------------------------------------------------------
module art_tier #(
   parameter int WINDOW      = art_pkg::WINDOW_DEF,
   parameter int PROMOTE_RUN = art_pkg::PROMOTE_RUN_DEF,
   parameter int COOLDOWN    = art_pkg::COOLDOWN_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  art_pkg::art_cfg_type                     cfg,
   input  logic                                     step,
   input  logic [art_pkg::LAT_W-1:0]                latency,
   input  logic [art_pkg::LAT_W+$clog2(WINDOW)-1:0] sum_upd,
   input  logic                                     full_upd,
   output art_pkg::art_tier_res_type                res
);

   localparam int SUM_W = art_pkg::LAT_W + $clog2(WINDOW);
   localparam int CMP_W = SUM_W + 3;
   localparam int ST_W  = $clog2(PROMOTE_RUN + 1);
   localparam int CD_W  = (COOLDOWN > 0) ? $clog2(COOLDOWN + 1) : 1;

   localparam logic [CMP_W-1:0] HI_RST = CMP_W'(7 * WINDOW * art_pkg::BUDGET_RESET);
   localparam logic [CMP_W-1:0] LO_RST = CMP_W'(3 * WINDOW * art_pkg::BUDGET_RESET);

   logic [art_pkg::BUDGET_W-1:0] budget_ff, budget_in;
   logic [CMP_W-1:0]             hi_ff, hi_in, lo_ff, lo_in, wb;
   logic [art_pkg::DIV_W-1:0]    div_ff, div_in;
   logic [ST_W-1:0]              streak_ff, streak_in, streak_inc;
   logic [CD_W-1:0]              cool_ff, cool_in;
   logic [CMP_W-1:0]             sum5;
   logic                         active, over, under, change;
   logic [art_pkg::DIV_W-1:0]    div_next;

   // thresholds follow budget writes: 7*W*b and 3*W*b
   always_comb begin
      budget_in = cfg.budget_wr ? cfg.data : budget_ff;
      wb        = CMP_W'(cfg.data) * CMP_W'(WINDOW);
      hi_in     = cfg.budget_wr ? CMP_W'(7) * wb : hi_ff;
      lo_in     = cfg.budget_wr ? CMP_W'(3) * wb : lo_ff;
   end

   always_comb begin
      active     = step && (budget_ff != '0);
      sum5       = (CMP_W'(sum_upd) << 2) + CMP_W'(sum_upd);
      over       = sum5 > hi_ff;
      under      = sum5 < lo_ff;
      streak_inc = streak_ff + 1'b1;
      change     = 1'b0;
      div_next   = div_ff;
      streak_in  = streak_ff;
      cool_in    = cool_ff;

      if (active) begin
         if (cool_ff != '0) begin
            cool_in = cool_ff - 1'b1;
         end else if (full_upd) begin
            if (over && (div_ff <= art_pkg::DIV_TWO)) begin
               change   = 1'b1;
               div_next = (div_ff <= art_pkg::DIV_ONE) ? art_pkg::DIV_TWO
                                                       : art_pkg::DIV_FOUR;
            end else if (under) begin
               if (streak_inc >= ST_W'(PROMOTE_RUN)) begin
                  streak_in = '0;
                  if (div_ff >= art_pkg::DIV_TWO) begin
                     change   = 1'b1;
                     div_next = (div_ff >= art_pkg::DIV_FOUR) ? art_pkg::DIV_TWO
                                                              : art_pkg::DIV_ONE;
                  end
               end else begin
                  streak_in = streak_inc;
               end
            end else begin
               streak_in = '0;
            end
         end
      end

      if (change) begin
         streak_in = '0;
         cool_in   = CD_W'(COOLDOWN);
      end

      div_in = div_next;
      if (cfg.toggle) begin
         streak_in = '0;
         cool_in   = '0;
      end
      if (cfg.div_wr) begin
         div_in = (cfg.data[art_pkg::DIV_W-1:0] == '0) ? art_pkg::DIV_ONE
                                                       : cfg.data[art_pkg::DIV_W-1:0];
      end

      res.divisor = div_in;
      res.overrun = active
                    && ({1'b0, latency} > {4'b0, budget_ff, 1'b0});
      res.changed = change;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= art_pkg::BUDGET_RESET;
         hi_ff     <= HI_RST;
         lo_ff     <= LO_RST;
         div_ff    <= art_pkg::DIV_ONE;
         streak_ff <= '0;
         cool_ff   <= '0;
      end else begin
         budget_ff <= budget_in;
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         div_ff    <= div_in;
         streak_ff <= streak_in;
         cool_ff   <= cool_in;
      end
   end

endmodule

// ===== src/adaptive_resolution_tier_governor.sv =====
// ----------------------------------------------------------------------------
// adaptive_resolution_tier_governor: render latency driven resolution tier
// Takes latency samples, keeps a windowed mean and steps the resolution
// divisor between 1, 2 and 4 against the frame budget.
// ----------------------------------------------------------------------------
// One sample is accepted every clock cycle while the input side is not
// stalled; its result is offered from the result register, after the sample
// has passed the input register. The input side stalls only while both
// registers hold items and the result is not being taken.
// A single decision path sits between the two registers: the running-sum
// update, the 5x mean compare against the registered budget thresholds and
// the divisor step. The ring of the last WINDOW samples sits in a small
// memory whose registered read always fetches the slot that the next sample
// will replace, so the oldest sample is ready for the running sum. Every
// sample gives exactly one result: the divisor after the sample, an overrun
// flag (sample above twice the budget) and a tier-changed flag. While
// adaptation is off the sample is dropped and the current divisor comes
// back with both flags clear. Configuration writes are always taken; they
// are meant to be made while no sample is in flight.
// ----------------------------------------------------------------------------
module adaptive_resolution_tier_governor #(
   parameter int WINDOW      = art_pkg::WINDOW_DEF,       // 2..256
   parameter int PROMOTE_RUN = art_pkg::PROMOTE_RUN_DEF,  // 1..255
   parameter int COOLDOWN    = art_pkg::COOLDOWN_DEF      // 0..255
) (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] latency_us
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] divisor, [4] overrun, [5] tier_changed, [7:6] 0
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int SUM_W = art_pkg::LAT_W + $clog2(WINDOW);

   // input stage
   logic                      in_valid_ff, in_valid_in;
   logic [art_pkg::LAT_W-1:0] lat_ff, lat_in;
   // result stage
   logic                      out_valid_ff, out_valid_in;
   art_pkg::art_tier_res_type out_ff, out_in;

   logic                      enable_ff, enable_in;
   logic                      advance;
   art_pkg::art_cfg_type      cfg;
   art_pkg::art_win_ctl_type  win_ctl;
   art_pkg::art_tier_res_type tier_res;
   logic [SUM_W-1:0]          sum_upd;
   logic                      full_upd;

   // register decode
   always_comb begin
      cfg       = '0;
      cfg.data  = csr_data;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (art_pkg::art_reg_type'(csr_index))
            art_pkg::REG_ENABLE: begin
               enable_in  = csr_data[0];
               cfg.toggle = csr_data[0] != enable_ff;
            end
            art_pkg::REG_BUDGET:    cfg.budget_wr = 1'b1;
            art_pkg::REG_START_DIV: cfg.div_wr    = 1'b1;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // the result register frees up whenever its item is taken, so the
   // input stage moves on in the same cycle
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tvalid || (in_valid_ff && !advance);
      lat_in       = (req_tvalid && req_tready) ? req_tdata : lat_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      out_in       = advance ? tier_res : out_ff;

      win_ctl.step  = advance && enable_ff;
      // an enable toggle or a tier change empties the window
      win_ctl.clear = cfg.toggle || tier_res.changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         enable_ff    <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_ff <= lat_in;
      out_ff <= out_in;
   end

   art_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .latency  (lat_ff),
      .sum_upd  (sum_upd),
      .full_upd (full_upd)
   );

   art_tier #(
      .WINDOW      (WINDOW),
      .PROMOTE_RUN (PROMOTE_RUN),
      .COOLDOWN    (COOLDOWN)
   ) u_tier (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (win_ctl.step),
      .latency  (lat_ff),
      .sum_upd  (sum_upd),
      .full_upd (full_upd),
      .res      (tier_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.changed, out_ff.overrun, out_ff.divisor};

endmodule

// ===== src/art_checker.sv =====
// ----------------------------------------------------------------------------
// art_checker: port-level checks for the tier governor
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module art_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // divisor is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] != 4'd0)
      else $error("divisor zero");

   // a tier step always lands on 1, 2 or 4
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |->
         (rsp_tdata[3:0] == 4'd1) || (rsp_tdata[3:0] == 4'd2) || (rsp_tdata[3:0] == 4'd4))
      else $error("tier change to odd divisor");

   // with the result side open, the sample side never stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with result side ready");

   // an offered sample waits only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("sample stalled without a waiting result");

endmodule

bind adaptive_resolution_tier_governor art_checker u_art_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
